FILE: hw/rtl/nacc_pkg.sv
// Shared constants, types and codes for the neuron activation accumulator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package nacc_pkg;

    // Number formats: values Q4.12, accumulator Q24.24
    localparam int VALUE_BITS = 16;
    localparam int ACC_BITS   = 48;
    localparam int VFRAC      = VALUE_BITS - 4;
    localparam int AFRAC      = 2 * VFRAC;

    // Multiplier operands carry one extra bit for the distance magnitude
    localparam int OPND_W  = VALUE_BITS + 1;
    localparam int PROD_W  = 2 * VALUE_BITS + 1;
    localparam int START_W = VALUE_BITS + 1 + VFRAC;

    // Square root: radicand is a non-negative sum scaled by 2^AFRAC
    localparam int RAD_W      = ACC_BITS - 1 + AFRAC;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Configuration port
    localparam int CFG_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_EN = 1'd1;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_DOT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPLIT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIST  = 2'd2;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // One classified operation for the back end
    typedef struct packed {
        logic                      first;
        logic                      last;
        logic                      is_dist;
        logic                      is_split;
        logic                      to_neg;
        logic signed [START_W-1:0] start;
        logic signed [PROD_W-1:0]  addend;
    } t_op;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_FIN,
        BK_ROOT
    } t_bk_state;

endpackage

FILE: hw/rtl/nacc_front.sv
// Front end: config registers, neuron-start tracking, multiply and op classification.
// Depends on nacc_pkg.
`timescale 1ns / 1ps

module nacc_front
    import nacc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_push,
    input  logic signed [VALUE_BITS-1:0] i_weight,
    input  logic signed [VALUE_BITS-1:0] i_source,
    input  logic signed [VALUE_BITS-1:0] i_theta,
    input  logic                        i_last,
    input  t_q_stat                     i_q_stat,
    output logic                        o_q_wr,
    output t_op                         o_op
);

    logic [MODE_W-1:0] r_mode;
    logic              r_thr_en;
    logic              r_first;
    logic              n_first;

    logic signed [OPND_W-1:0]   w_ext;
    logic signed [OPND_W-1:0]   s_ext;
    logic signed [OPND_W-1:0]   th_ext;
    logic signed [OPND_W-1:0]   diff;
    logic signed [OPND_W-1:0]   dmag;
    logic signed [OPND_W-1:0]   opa;
    logic signed [OPND_W-1:0]   opb;
    logic signed [2*OPND_W-1:0] prod;
    logic signed [OPND_W-1:0]   neg_th;
    logic                       is_dist;
    logic                       is_split;

    assign o_q_wr = i_push && !i_q_stat.full;
    assign n_first = o_q_wr ? i_last : r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_DOT;
            r_thr_en <= 1'b0;
            r_first  <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                    CFG_THR_EN: r_thr_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_first <= n_first;
        end
    end

    always_comb begin
        w_ext    = OPND_W'(i_weight);
        s_ext    = OPND_W'(i_source);
        th_ext   = OPND_W'(i_theta);
        diff     = s_ext - w_ext;
        dmag     = diff[OPND_W-1] ? -diff : diff;
        is_dist  = (r_mode == MODE_DIST);
        is_split = (r_mode == MODE_SPLIT);
        opa      = is_dist ? dmag : w_ext;
        opb      = is_dist ? dmag : s_ext;
        prod     = opa * opb;
        neg_th   = -th_ext;

        o_op.first    = r_first;
        o_op.last     = i_last;
        o_op.is_dist  = is_dist;
        o_op.is_split = is_split;
        // zero weight counts as non-negative
        o_op.to_neg   = is_split && i_weight[VALUE_BITS-1];
        o_op.start    = r_thr_en ? $signed({neg_th, {VFRAC{1'b0}}}) : '0;
        o_op.addend   = $signed(prod[PROD_W-1:0]);
    end

endmodule

FILE: hw/rtl/nacc_queue.sv
// Short op queue decoupling front and back ends.
// Depends on nacc_pkg.
`timescale 1ns / 1ps

module nacc_queue
    import nacc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_op     i_wr_op,
    input  logic    i_rd,
    output t_op     o_rd_op,
    output t_q_stat o_stat
);

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_PTR_W:0]   r_count;

    assign o_rd_op      = r_mem[r_rptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wr_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/nacc_root.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nacc_pkg.
`timescale 1ns / 1ps

module nacc_root
    import nacc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ACC_BITS-2:0]   i_radicand,
    input  logic                  i_ack,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic [ROOT_W-1:0]     o_root
);

    logic [2*ROOT_W-1:0]   r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_valid;

    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  take;

    assign o_busy  = r_busy;
    assign o_valid = r_valid;
    assign o_root  = r_root;

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[2*ROOT_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= (2*ROOT_W)'({i_radicand, {AFRAC{1'b0}}});
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*ROOT_W-3:0], 2'b00};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_cnt   <= ROOT_CNT_W'(ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ROOT_CNT_W'(1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end else if (r_valid && i_ack) begin
            r_valid <= 1'b0;
        end
    end

endmodule

FILE: hw/rtl/nacc_back.sv
// Back end: saturating accumulation, neuron finish, result register.
// Depends on nacc_pkg; drives the nacc_root unit through the top level.
`timescale 1ns / 1ps

module nacc_back
    import nacc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_op                         i_op,
    input  t_q_stat                     i_q_stat,
    output logic                        o_q_rd,
    output logic                        o_root_start,
    output logic [ACC_BITS-2:0]         o_root_radicand,
    input  logic                        i_root_valid,
    input  logic [ROOT_W-1:0]           i_root,
    output logic                        o_root_ack,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic signed [ACC_BITS-1:0]  o_activation,
    output logic                        o_saturated
);

    t_bk_state r_state;
    t_bk_state n_state;

    logic signed [ACC_BITS-1:0] r_main;
    logic signed [ACC_BITS-1:0] r_neg;
    logic                       r_ovf;
    logic                       r_is_dist;
    logic                       r_is_split;
    logic                       r_out_valid;
    logic signed [ACC_BITS-1:0] r_out_act;
    logic                       r_out_sat;

    logic signed [ACC_BITS-1:0] base_main;
    logic signed [ACC_BITS-1:0] base_neg;
    logic                       base_ovf;
    logic signed [ACC_BITS-1:0] tgt;
    logic signed [ACC_BITS:0]   sum;
    logic                       add_ovf;
    logic signed [ACC_BITS-1:0] sat_sum;

    logic [ACC_BITS-1:0]        mag_main;
    logic [ACC_BITS-1:0]        mag_neg;
    logic                       slot_free;
    logic                       out_wr;
    logic signed [ACC_BITS-1:0] out_act;
    logic                       out_sat;

    assign slot_free    = !r_out_valid || i_pop;
    assign o_empty      = !r_out_valid;
    assign o_activation = r_out_act;
    assign o_saturated  = r_out_sat;
    assign o_root_radicand = r_main[ACC_BITS-2:0];

    // saturating add into the selected sum
    always_comb begin
        base_main = i_op.first ? ACC_BITS'(i_op.start) : r_main;
        base_neg  = i_op.first ? ACC_BITS'(i_op.start) : r_neg;
        base_ovf  = i_op.first ? 1'b0 : r_ovf;
        tgt       = i_op.to_neg ? base_neg : base_main;
        sum       = (ACC_BITS+1)'(tgt) + (ACC_BITS+1)'(i_op.addend);
        add_ovf   = (sum[ACC_BITS] != sum[ACC_BITS-1]);
        sat_sum   = add_ovf ? (sum[ACC_BITS] ? ACC_MIN : ACC_MAX) : sum[ACC_BITS-1:0];
        mag_main  = r_main[ACC_BITS-1] ? -r_main : r_main;
        mag_neg   = r_neg[ACC_BITS-1] ? -r_neg : r_neg;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN: begin
                if (!i_q_stat.empty && i_op.last) n_state = BK_FIN;
            end
            BK_FIN: begin
                if (r_is_dist && !r_main[ACC_BITS-1]) n_state = BK_ROOT;
                else if (slot_free) n_state = BK_RUN;
            end
            BK_ROOT: begin
                if (i_root_valid && slot_free) n_state = BK_RUN;
            end
            default: n_state = BK_RUN;
        endcase
    end

    always_comb begin
        o_q_rd       = 1'b0;
        o_root_start = 1'b0;
        o_root_ack   = 1'b0;
        out_wr       = 1'b0;
        out_act      = r_main;
        out_sat      = r_ovf;
        case (r_state)
            BK_RUN: begin
                o_q_rd = !i_q_stat.empty;
            end
            BK_FIN: begin
                if (r_is_dist && !r_main[ACC_BITS-1]) begin
                    o_root_start = 1'b1;
                end else begin
                    out_wr = slot_free;
                    if (r_is_dist) begin
                        // negative distance sum clamps to zero
                        out_act = '0;
                        out_sat = 1'b1;
                    end else if (r_is_split) begin
                        // tie goes to the negative-weight sum
                        out_act = (mag_main > mag_neg) ? r_main : r_neg;
                    end
                end
            end
            BK_ROOT: begin
                out_wr     = i_root_valid && slot_free;
                o_root_ack = out_wr;
                out_act    = $signed(ACC_BITS'(i_root));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_main     <= i_op.to_neg ? base_main : sat_sum;
            r_neg      <= i_op.to_neg ? sat_sum : base_neg;
            r_is_dist  <= i_op.is_dist;
            r_is_split <= i_op.is_split;
        end
        if (out_wr) begin
            r_out_act <= out_act;
            r_out_sat <= out_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_RUN;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_q_rd) begin
                r_ovf <= base_ovf || add_ovf;
            end
            if (out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/neuron_activation_accumulator.sv
// Throughput: one (weight, source) transfer per cycle while full is low; closing a neuron
// holds the back end in its finish state (and while the root runs in distance mode), and
// full rises once the 4-entry op queue backs up. The last transfer of a neuron passes the
// op queue, back-end sums and result register; distance mode adds the bit-serial root.
// A result nobody pops holds the back end too. Reset (i_rst_n low at a clock edge,
// synchronous): queue and result empty, mode dot, threshold off, next transfer opens a neuron.
`timescale 1ns / 1ps

module neuron_activation_accumulator
    import nacc_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration writes: index 0 mode, index 1 threshold enable
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    // input side: transfer on push && !full
    input  logic                         push,
    output logic                         full,
    input  logic signed [VALUE_BITS-1:0] i_weight,
    input  logic signed [VALUE_BITS-1:0] i_source,
    input  logic signed [VALUE_BITS-1:0] i_theta,
    input  logic                         i_last,
    // result side: transfer on pop && !empty
    output logic                         empty,
    input  logic                         pop,
    output logic signed [ACC_BITS-1:0]   o_activation,
    output logic                         o_saturated
);

    // front -> queue
    logic    q_wr;
    t_op     wr_op;
    t_op     rd_op;
    logic    q_rd;
    t_q_stat q_stat;

    // back <-> root unit
    logic                root_start;
    logic [ACC_BITS-2:0] root_radicand;
    logic                root_busy;
    logic                root_valid;
    logic [ROOT_W-1:0]   root_val;
    logic                root_ack;

    assign full = q_stat.full;

    // Front: tracks neuron boundaries, multiplies (product or squared
    // difference), and picks the start value used on the first transfer.
    nacc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_weight    (i_weight),
        .i_source    (i_source),
        .i_theta     (i_theta),
        .i_last      (i_last),
        .i_q_stat    (q_stat),
        .o_q_wr      (q_wr),
        .o_op        (wr_op)
    );

    // Queue holds registered products so the front keeps streaming
    // while the back waits on the root or a full result register.
    nacc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wr_op (wr_op),
        .i_rd    (q_rd),
        .o_rd_op (rd_op),
        .o_stat  (q_stat)
    );

    // Back: saturating sums, sign-split select, result register.
    nacc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (rd_op),
        .i_q_stat        (q_stat),
        .o_q_rd          (q_rd),
        .o_root_start    (root_start),
        .o_root_radicand (root_radicand),
        .i_root_valid    (root_valid),
        .i_root          (root_val),
        .o_root_ack      (root_ack),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_activation    (o_activation),
        .o_saturated     (o_saturated)
    );

    // Bit-serial root of the distance sum scaled into Q24.24.
    nacc_root u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (root_radicand),
        .i_ack      (root_ack),
        .o_busy     (root_busy),
        .o_valid    (root_valid),
        .o_root     (root_val)
    );

    // Internal consistency checks
    a_q_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> !q_stat.full)
        else $error("op queue written while full");

    a_q_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_stat.empty)
        else $error("op queue read while empty");

    a_root_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_start |-> (!root_busy && !root_valid))
        else $error("root unit started while in use");

    a_root_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (root_valid && !root_ack) |=> (root_valid && $stable(root_val)))
        else $error("root result dropped before use");

endmodule
